// ===== rtl/core/npip_pkg.sv =====
// Package with types, constants and helpers shared by the palette index packer.
`timescale 1ns / 1ps
`default_nettype none
package npip_pkg;

    // Store sizes. The cache depth is a power of two, so the key is a bit-select.
    localparam int PALETTE_ENTRIES = 256;
    localparam int CACHE_ENTRIES   = 1024;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
    localparam int PAL_CW          = $clog2(PALETTE_ENTRIES + 1);
    localparam int CACHE_AW        = $clog2(CACHE_ENTRIES);

    // Largest distance is 3 * 255 * 255, which fits in 18 bits.
    localparam int DIST_W = 18;
    localparam logic [DIST_W-1:0] NO_DISTANCE = '1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEPTH_MODE    = 2'd0;
    localparam logic [1:0] CFG_PALETTE_COUNT = 2'd1;

    // Depth modes.
    localparam logic [2:0] DM_8BIT     = 3'd0;
    localparam logic [2:0] DM_4BIT     = 3'd1;
    localparam logic [2:0] DM_2BIT     = 3'd2;
    localparam logic [2:0] DM_1BIT_MSB = 3'd3;
    localparam logic [2:0] DM_1BIT_LSB = 3'd4;

    // Input opcodes.
    localparam logic OP_PALETTE_WRITE = 1'b0;
    localparam logic OP_PIXEL         = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] palette_slot;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       start_of_image;
        logic       end_of_row;
    } in_word_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       row_done;
    } out_word_t;

    // Word handed from one distance cell to the next.
    typedef struct packed {
        logic              valid;
        logic [7:0]        idx;
        logic              last;
        logic [23:0]       ent;
        logic [23:0]       pix;
        logic [DIST_W-1:0] sum;
    } cell_word_t;

    typedef struct packed {
        logic       start;
        logic [23:0] pix;
    } srch_req_t;

    typedef struct packed {
        logic        en;
        logic [7:0]  slot;
        logic [23:0] color;
    } srch_wr_t;

    typedef struct packed {
        logic       done;
        logic [7:0] idx;
    } srch_rsp_t;

    // Cache entry: valid, color key and palette index.
    typedef struct packed {
        logic        valid;
        logic [23:0] rgb;
        logic [7:0]  idx;
    } cache_word_t;

endpackage
`default_nettype wire

// ===== rtl/core/npip_cell.sv =====
// Distance cell: adds the squared difference of one color channel and passes the word on.
`timescale 1ns / 1ps
`default_nettype none
module npip_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                flush,
    input  wire npip_pkg::cell_word_t din,
    output npip_pkg::cell_word_t     dout
);

    logic [7:0]                 diff;
    logic [15:0]                sq;
    npip_pkg::cell_word_t       data_next;
    npip_pkg::cell_word_t       data_reg;
    logic                       valid_reg;

    // Top byte is this cell's channel; the rest shifts up for the next cell.
    always_comb
    begin
        diff = (din.ent[23:16] > din.pix[23:16]) ? (din.ent[23:16] - din.pix[23:16])
                                                 : (din.pix[23:16] - din.ent[23:16]);
        sq = diff * diff;
        data_next     = din;
        data_next.ent = {din.ent[15:0], 8'd0};
        data_next.pix = {din.pix[15:0], 8'd0};
        data_next.sum = din.sum + npip_pkg::DIST_W'(sq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= din.valid && !flush;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        dout       = data_reg;
        dout.valid = valid_reg;
    end

endmodule
`default_nettype wire

// ===== rtl/core/npip_search.sv =====
// Palette store and nearest-entry search through a chain of three distance cells.
`timescale 1ns / 1ps
`default_nettype none
module npip_search (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [8:0]          palette_count,
    input  wire npip_pkg::srch_wr_t  wr,
    input  wire npip_pkg::srch_req_t req,
    output npip_pkg::srch_rsp_t      rsp
);

    logic [23:0] pal_mem [npip_pkg::PALETTE_ENTRIES];

    logic                            busy_reg;
    logic                            issue_reg;
    logic [npip_pkg::PAL_AW-1:0]     addr_reg;
    logic [23:0]                     pix_reg;
    logic [npip_pkg::PAL_CW-1:0]     count_reg;
    logic [npip_pkg::PAL_CW-1:0]     n_eff;
    logic [23:0]                     rd_data_reg;
    logic                            rd_valid_reg;
    logic [7:0]                      rd_idx_reg;
    logic                            rd_last_reg;
    logic [npip_pkg::DIST_W-1:0]     best_reg;
    logic [7:0]                      found_reg;
    logic                            done_reg;
    logic                            issue_last;
    logic                            less;
    logic                            finish;
    npip_pkg::cell_word_t            chain [4];

    // Palette writes beyond the store are dropped.
    always_ff @(posedge clk)
    begin
        if (wr.en && ({1'b0, wr.slot} < 9'(npip_pkg::PALETTE_ENTRIES)))
        begin
            pal_mem[npip_pkg::PAL_AW'(wr.slot)] <= wr.color;
        end
        rd_data_reg <= pal_mem[addr_reg];
    end

    // Effective entry count saturates at the store depth.
    always_comb
    begin
        n_eff = (palette_count > 9'(npip_pkg::PALETTE_ENTRIES))
              ? npip_pkg::PAL_CW'(npip_pkg::PALETTE_ENTRIES)
              : npip_pkg::PAL_CW'(palette_count);
        issue_last = (npip_pkg::PAL_CW'(addr_reg) + 1'b1) == count_reg;
    end

    // Feed the chain with the entry just read.
    always_comb
    begin
        chain[0].valid = rd_valid_reg;
        chain[0].idx   = rd_idx_reg;
        chain[0].last  = rd_last_reg;
        chain[0].ent   = rd_data_reg;
        chain[0].pix   = pix_reg;
        chain[0].sum   = '0;
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_cell
        npip_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .flush (finish),
            .din   (chain[k]),
            .dout  (chain[k+1])
        );
    end

    // First strict minimum wins; an exact match or the last entry ends the walk.
    always_comb
    begin
        less   = chain[3].sum < best_reg;
        finish = busy_reg && chain[3].valid
              && ((less && (chain[3].sum == '0)) || chain[3].last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            issue_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg     <= req.start ? (n_eff == '0) : finish;
            rd_valid_reg <= issue_reg && !finish;
            if (req.start)
            begin
                if (n_eff != '0)
                begin
                    busy_reg  <= 1'b1;
                    issue_reg <= 1'b1;
                end
            end
            else if (finish)
            begin
                busy_reg  <= 1'b0;
                issue_reg <= 1'b0;
            end
            else if (issue_reg && issue_last)
            begin
                issue_reg <= 1'b0;
            end
        end
    end

    // Search datapath registers.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            addr_reg  <= '0;
            pix_reg   <= req.pix;
            count_reg <= n_eff;
            best_reg  <= npip_pkg::NO_DISTANCE;
            found_reg <= 8'd0;
        end
        else
        begin
            if (issue_reg)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
            if (busy_reg && chain[3].valid && less)
            begin
                found_reg <= chain[3].idx;
                best_reg  <= chain[3].sum;
            end
        end
        rd_idx_reg  <= 8'(addr_reg);
        rd_last_reg <= issue_last;
    end

    assign rsp.done = done_reg;
    assign rsp.idx  = found_reg;

endmodule
`default_nettype wire

// ===== rtl/core/nearest_palette_index_packer.sv =====
// Top level: color cache, control sequencer and index packer around the palette search.
// A cache hit passes the key, read, lookup and pack states before the next word is accepted.
// A miss adds the palette walk over the configured entries, which is empty when the count is zero.
// A pixel with start of image first sweeps all CACHE_ENTRIES cache slots, one slot a cycle.
// Palette writes leave the sequencer idle. Results wait in an output register while work goes on.
// After reset all cache slots are swept before the first word is taken.
`timescale 1ns / 1ps
`default_nettype none
module nearest_palette_index_packer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire npip_pkg::in_word_t in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output npip_pkg::out_word_t     out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [8:0]         cfg_data
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_KEY,
        S_READ,
        S_LOOK,
        S_WAIT,
        S_PACK
    } state_t;

    state_t                          state_reg;
    logic [2:0]                      depth_mode_reg;
    logic [8:0]                      palette_count_reg;
    logic                            pend_reg;
    logic [npip_pkg::CACHE_AW-1:0]   clr_addr_reg;
    logic [23:0]                     pix_reg;
    logic                            eor_reg;
    logic [15:0]                     rg_reg;
    logic [23:0]                     rgb_prod;
    logic [npip_pkg::CACHE_AW-1:0]   key_reg;
    logic [7:0]                      idx_reg;
    logic [7:0]                      acc_reg;
    logic [2:0]                      pack_fill_reg;
    logic                            out_valid_reg;
    npip_pkg::out_word_t             out_reg;

    npip_pkg::cache_word_t           cache_mem [npip_pkg::CACHE_ENTRIES];
    npip_pkg::cache_word_t           cache_rd_reg;
    npip_pkg::cache_word_t           cache_wdata;
    logic [npip_pkg::CACHE_AW-1:0]   cache_waddr;
    logic                            cache_we;
    logic                            hit;
    logic                            accept;

    npip_pkg::srch_wr_t              srch_wr;
    npip_pkg::srch_req_t             srch_req;
    npip_pkg::srch_rsp_t             srch_rsp;

    logic [1:0]                      bits_log;
    logic                            lsb_first;
    logic [3:0]                      slots;
    logic [7:0]                      mask;
    logic [3:0]                      fill_cur;
    logic [3:0]                      fill_inc;
    logic [3:0]                      shift;
    logic [7:0]                      acc_next;
    logic                            emit;
    logic                            out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_mode_reg    <= npip_pkg::DM_8BIT;
            palette_count_reg <= 9'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                npip_pkg::CFG_DEPTH_MODE:    depth_mode_reg    <= cfg_data[2:0];
                npip_pkg::CFG_PALETTE_COUNT: palette_count_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // Palette search unit.
    always_comb
    begin
        srch_wr.en    = accept && (in_data.opcode == npip_pkg::OP_PALETTE_WRITE);
        srch_wr.slot  = in_data.palette_slot;
        srch_wr.color = {in_data.red, in_data.green, in_data.blue};
        srch_req.start = (state_reg == S_LOOK) && !hit;
        srch_req.pix   = pix_reg;
    end

    npip_search u_search (
        .clk           (clk),
        .rst_n         (rst_n),
        .palette_count (palette_count_reg),
        .wr            (srch_wr),
        .req           (srch_req),
        .rsp           (srch_rsp)
    );

    // Cache: one write port shared by the sweep and miss fills, one registered read.
    assign hit = cache_rd_reg.valid && (cache_rd_reg.rgb == pix_reg);

    always_comb
    begin
        cache_we          = 1'b0;
        cache_waddr       = key_reg;
        cache_wdata.valid = 1'b1;
        cache_wdata.rgb   = pix_reg;
        cache_wdata.idx   = srch_rsp.idx;
        if (state_reg == S_CLEAR)
        begin
            cache_we    = 1'b1;
            cache_waddr = clr_addr_reg;
            cache_wdata = '0;
        end
        else if ((state_reg == S_WAIT) && srch_rsp.done)
        begin
            cache_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cache_we)
        begin
            cache_mem[cache_waddr] <= cache_wdata;
        end
        cache_rd_reg <= cache_mem[key_reg];
    end

    // Key is the low bits of red*green*blue.
    assign rgb_prod = rg_reg * pix_reg[7:0];

    // Packing of the index into the byte.
    always_comb
    begin
        lsb_first = 1'b0;
        case (depth_mode_reg)
            npip_pkg::DM_4BIT:     bits_log = 2'd2;
            npip_pkg::DM_2BIT:     bits_log = 2'd1;
            npip_pkg::DM_1BIT_MSB: bits_log = 2'd0;
            npip_pkg::DM_1BIT_LSB:
            begin
                bits_log  = 2'd0;
                lsb_first = 1'b1;
            end
            default:               bits_log = 2'd3;
        endcase
        slots    = 4'd8 >> bits_log;
        mask     = 8'((9'd1 << (4'd1 << bits_log)) - 9'd1);
        fill_cur = ({1'b0, pack_fill_reg} >= slots) ? (slots - 4'd1) : {1'b0, pack_fill_reg};
        fill_inc = fill_cur + 4'd1;
        shift    = lsb_first ? fill_cur : (4'd8 - (fill_inc << bits_log));
        acc_next = acc_reg | 8'((idx_reg & mask) << shift);
        emit     = (fill_inc >= slots) || eor_reg;
    end

    // Sequencer with its registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            pend_reg      <= 1'b0;
            clr_addr_reg  <= '0;
            acc_reg       <= 8'd0;
            pack_fill_reg <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_PACK) && emit && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == npip_pkg::CACHE_AW'(npip_pkg::CACHE_ENTRIES - 1))
                    begin
                        state_reg <= pend_reg ? S_KEY : S_IDLE;
                        pend_reg  <= 1'b0;
                    end
                end
                S_IDLE:
                begin
                    if (accept && (in_data.opcode == npip_pkg::OP_PIXEL))
                    begin
                        if (in_data.start_of_image)
                        begin
                            acc_reg       <= 8'd0;
                            pack_fill_reg <= 3'd0;
                            pend_reg      <= 1'b1;
                            state_reg     <= S_CLEAR;
                        end
                        else
                        begin
                            state_reg <= S_KEY;
                        end
                    end
                end
                S_KEY:  state_reg <= S_READ;
                S_READ: state_reg <= S_LOOK;
                S_LOOK: state_reg <= hit ? S_PACK : S_WAIT;
                S_WAIT:
                begin
                    if (srch_rsp.done)
                    begin
                        state_reg <= S_PACK;
                    end
                end
                S_PACK:
                begin
                    if (!emit)
                    begin
                        acc_reg       <= acc_next;
                        pack_fill_reg <= fill_inc[2:0];
                        state_reg     <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        acc_reg       <= 8'd0;
                        pack_fill_reg <= 3'd0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg <= {in_data.red, in_data.green, in_data.blue};
            eor_reg <= in_data.end_of_row;
            rg_reg  <= in_data.red * in_data.green;
        end
        if (state_reg == S_KEY)
        begin
            key_reg <= rgb_prod[npip_pkg::CACHE_AW-1:0];
        end
        if ((state_reg == S_LOOK) && hit)
        begin
            idx_reg <= cache_rd_reg.idx;
        end
        else if ((state_reg == S_WAIT) && srch_rsp.done)
        begin
            idx_reg <= srch_rsp.idx;
        end
        if ((state_reg == S_PACK) && emit && out_free)
        begin
            out_reg.packed_byte <= acc_next;
            out_reg.row_done    <= eor_reg;
        end
    end

    // A search answer only arrives while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        srch_rsp.done |-> (state_reg == S_WAIT))
        else $error("search answer outside wait state");

    // A new result leaves the packer empty.
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (pack_fill_reg == 3'd0) && (acc_reg == 8'd0))
        else $error("packer not cleared after emit");

    // A cache hit goes straight to packing.
    a_hit_to_pack: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK) && hit |=> (state_reg == S_PACK))
        else $error("cache hit did not go to packing");

endmodule
`default_nettype wire

// ===== tb/sv/nearest_palette_index_packer_test.sv =====
// Self-checking testbench for the nearest palette index packer.
`timescale 1ns / 1ps
`default_nettype none
module nearest_palette_index_packer_test;

    localparam int CLK_PERIOD  = 8;
    localparam int DRAIN_WAIT  = 1400;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int N_PHASES    = 10;
    localparam int PHASE_ITEMS = 118;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    npip_pkg::in_word_t  in_data;
    logic                out_valid;
    logic                out_stall = 1'b0;
    npip_pkg::out_word_t out_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [8:0]          cfg_data;

    nearest_palette_index_packer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Shadow copy of the block state used to predict packed bytes.
    logic [23:0] pal_color [npip_pkg::PALETTE_ENTRIES];
    bit          cache_hit_ok [npip_pkg::CACHE_ENTRIES];
    logic [23:0] cache_rgb [npip_pkg::CACHE_ENTRIES];
    logic [7:0]  cache_index [npip_pkg::CACHE_ENTRIES];
    logic [7:0]  acc_byte;
    int          acc_fill;
    logic [2:0]  cur_depth;
    logic [8:0]  cur_count;

    npip_pkg::out_word_t byte_q[$];
    int  mismatches = 0;
    int  pixels_sent;
    int  pal_writes_sent;
    int  bytes_seen = 0;
    int  sender_idle_pct;
    int  receiver_idle_pct;
    bit  pause_req;
    int  cycle_count = 0;
    logic [23:0] color_pool [16];

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Nearest palette entry: first minimum wins, an exact match stops the walk.
    function automatic logic [7:0] nearest_entry(input logic [23:0] pix);
        int n;
        int best;
        int sq_dist;
        int dr;
        int dg;
        int db;
        logic [7:0] found;
        n = (cur_count > npip_pkg::PALETTE_ENTRIES) ? npip_pkg::PALETTE_ENTRIES
                                                    : int'(cur_count);
        best = 32'h7fffffff;
        found = 8'd0;
        for (int j = 0; j < n; j++)
        begin
            dr = int'(pal_color[j][23:16]) - int'(pix[23:16]);
            dg = int'(pal_color[j][15:8]) - int'(pix[15:8]);
            db = int'(pal_color[j][7:0]) - int'(pix[7:0]);
            sq_dist = dr * dr + dg * dg + db * db;
            if (sq_dist < best)
            begin
                found = j[7:0];
                if (sq_dist == 0)
                    break;
                best = sq_dist;
            end
        end
        return found;
    endfunction

    // Update the shadow state for one accepted word; returns 1 if a byte is due.
    function automatic bit predict_word(input npip_pkg::in_word_t w,
                                        output npip_pkg::out_word_t res);
        int key;
        int bits;
        int slots;
        int fill;
        int shift;
        bit lsb_first;
        logic [7:0] idx;
        logic [23:0] pix;
        res = '0;
        if (w.opcode == npip_pkg::OP_PALETTE_WRITE)
        begin
            pal_color[w.palette_slot] = {w.red, w.green, w.blue};
            return 1'b0;
        end
        if (w.start_of_image)
        begin
            foreach (cache_hit_ok[i])
                cache_hit_ok[i] = 1'b0;
            acc_byte = 8'd0;
            acc_fill = 0;
        end
        pix = {w.red, w.green, w.blue};
        key = (int'(w.red) * int'(w.green) * int'(w.blue)) % npip_pkg::CACHE_ENTRIES;
        if (cache_hit_ok[key] && cache_rgb[key] == pix)
            idx = cache_index[key];
        else
        begin
            idx = nearest_entry(pix);
            cache_hit_ok[key] = 1'b1;
            cache_rgb[key] = pix;
            cache_index[key] = idx;
        end
        lsb_first = 1'b0;
        case (cur_depth)
            npip_pkg::DM_4BIT:     bits = 4;
            npip_pkg::DM_2BIT:     bits = 2;
            npip_pkg::DM_1BIT_MSB: bits = 1;
            npip_pkg::DM_1BIT_LSB:
            begin
                bits = 1;
                lsb_first = 1'b1;
            end
            default:               bits = 8;
        endcase
        slots = 8 / bits;
        fill = acc_fill;
        if (fill >= slots)
            fill = slots - 1;
        shift = lsb_first ? fill : 8 - bits * (fill + 1);
        acc_byte = acc_byte | 8'((int'(idx) & ((1 << bits) - 1)) << shift);
        fill++;
        if (fill >= slots || w.end_of_row)
        begin
            res.packed_byte = acc_byte;
            res.row_done = w.end_of_row;
            acc_byte = 8'd0;
            acc_fill = 0;
            return 1'b1;
        end
        acc_fill = fill;
        return 1'b0;
    endfunction

    // Hand one word to the block, with optional idle gap or drain pause first.
    task automatic push_word(input npip_pkg::in_word_t w, input bit typed,
                             input npip_pkg::out_word_t typed_res);
        npip_pkg::out_word_t res;
        int gap;
        gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 4) : 0;
        if (pause_req)
        begin
            in_valid <= 1'b0;
            while (byte_q.size() != 0)
                @(posedge clk);
            pause_req = 1'b0;
        end
        else if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (in_stall);
        if (w.opcode == npip_pkg::OP_PIXEL)
            pixels_sent++;
        else
            pal_writes_sent++;
        if (predict_word(w, res))
            byte_q.push_back(typed ? typed_res : res);
    endtask

    // Wait until the block is idle, then write one register.
    task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
        in_valid <= 1'b0;
        while (byte_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == npip_pkg::CFG_DEPTH_MODE)
            cur_depth = val[2:0];
        else
            cur_count = val;
    endtask

    function automatic npip_pkg::in_word_t make_pixel(input logic [23:0] c, input bit soi,
                                                      input bit eor);
        npip_pkg::in_word_t w;
        w = '0;
        w.opcode = npip_pkg::OP_PIXEL;
        w.palette_slot = 8'($urandom);
        {w.red, w.green, w.blue} = c;
        w.start_of_image = soi;
        w.end_of_row = eor;
        return w;
    endfunction

    function automatic npip_pkg::in_word_t make_pal_write(input logic [7:0] slot,
                                                          input logic [23:0] c);
        npip_pkg::in_word_t w;
        w = '0;
        w.opcode = npip_pkg::OP_PALETTE_WRITE;
        w.palette_slot = slot;
        {w.red, w.green, w.blue} = c;
        w.start_of_image = 1'($urandom);
        w.end_of_row = 1'($urandom);
        return w;
    endfunction

    // Pixel colors: half from a pool of repeats for cache hits, some exact palette colors, random colors and extremes.
    function automatic logic [23:0] pick_color();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50)
            return color_pool[$urandom_range(15)];
        else if (sel < 65)
            return pal_color[$urandom_range(npip_pkg::PALETTE_ENTRIES - 1)];
        else if (sel < 95)
            return 24'($urandom);
        else
            return {($urandom_range(1) ? 8'hff : 8'h00), ($urandom_range(1) ? 8'hff : 8'h00),
                    ($urandom_range(1) ? 8'hff : 8'h00)};
    endfunction

    // Images made of rows, with palette rewrites and some broken framing mixed in.
    task automatic run_random(input int n_items);
        int img_left;
        int row_left;
        bit soi;
        bit eor;
        img_left = 0;
        row_left = 0;
        for (int k = 0; k < n_items; k++)
        begin
            if (k == n_items / 2)
                pause_req = 1'b1;
            if ($urandom_range(99) < 3)
                color_pool[$urandom_range(15)] = 24'($urandom);
            if ($urandom_range(99) < 7)
            begin
                push_word(make_pal_write(8'($urandom), 24'($urandom)), 1'b0, '0);
                continue;
            end
            soi = 1'b0;
            if (img_left == 0)
            begin
                img_left = $urandom_range(20, 60);
                soi = 1'b1;
            end
            if (row_left == 0)
                row_left = $urandom_range(1, 12);
            eor = (row_left == 1);
            if ($urandom_range(99) < 5)
                eor = 1'($urandom);
            if ($urandom_range(99) < 1)
                soi = 1'b1;
            push_word(make_pixel(pick_color(), soi, eor), 1'b0, '0);
            img_left--;
            row_left--;
        end
    endtask

    // Receiver: random stall, compare each accepted byte with the oldest expectation.
    always @(posedge clk)
    begin
        npip_pkg::out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            bytes_seen++;
            if (byte_q.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h", out_data.packed_byte));
            else
            begin
                want = byte_q.pop_front();
                if (out_data.packed_byte !== want.packed_byte)
                    report_mismatch($sformatf("packed_byte %02h, expected %02h",
                                              out_data.packed_byte, want.packed_byte));
                if (out_data.row_done !== want.row_done)
                    report_mismatch($sformatf("row_done %0b, expected %0b",
                                              out_data.row_done, want.row_done));
            end
        end
        out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("nearest_palette_index_packer regression: fail");
            $finish;
        end
    end

    typedef struct {
        npip_pkg::in_word_t  w;
        bit                  typed;
        npip_pkg::out_word_t res;
    } stim_row_t;

    initial
    begin
        stim_row_t dir_rows[$];
        logic [2:0] ph_depth [N_PHASES];
        logic [8:0] ph_count [N_PHASES];
        ph_depth = '{npip_pkg::DM_8BIT, npip_pkg::DM_4BIT, npip_pkg::DM_2BIT,
                     npip_pkg::DM_1BIT_MSB, npip_pkg::DM_1BIT_LSB,
                     3'd5, 3'd6, 3'd7, npip_pkg::DM_4BIT, npip_pkg::DM_1BIT_LSB};
        ph_count = '{9'd256, 9'd16, 9'd1, 9'd255, 9'd2, 9'd0, 9'd511, 9'd128, 9'd256, 9'd7};
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = npip_pkg::CFG_DEPTH_MODE;
        cfg_data = '0;
        rst_n = 1'b0;
        pixels_sent = 0;
        pal_writes_sent = 0;
        pause_req = 1'b0;
        sender_idle_pct = 25;
        receiver_idle_pct = 52;
        foreach (pal_color[i])
            pal_color[i] = 24'd0;
        foreach (cache_hit_ok[i])
            cache_hit_ok[i] = 1'b0;
        foreach (color_pool[i])
            color_pool[i] = 24'($urandom);
        acc_byte = 8'd0;
        acc_fill = 0;
        cur_depth = npip_pkg::DM_8BIT;
        cur_count = 9'd256;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: four entries, black, white, red, blue; only these are searched.
        write_reg(npip_pkg::CFG_PALETTE_COUNT, 9'd4);
        dir_rows.push_back('{make_pal_write(8'd0, 24'h000000), 1'b0, '0});
        dir_rows.push_back('{make_pal_write(8'd1, 24'hffffff), 1'b0, '0});
        dir_rows.push_back('{make_pal_write(8'd2, 24'hff0000), 1'b0, '0});
        dir_rows.push_back('{make_pal_write(8'd3, 24'h0000ff), 1'b0, '0});
        dir_rows.push_back('{make_pixel(24'h000000, 1'b1, 1'b0), 1'b1, '{8'h00, 1'b0}});
        dir_rows.push_back('{make_pixel(24'hffffff, 1'b0, 1'b0), 1'b1, '{8'h01, 1'b0}});
        dir_rows.push_back('{make_pixel(24'hff0000, 1'b0, 1'b1), 1'b1, '{8'h02, 1'b1}});
        dir_rows.push_back('{make_pixel(24'h0000ff, 1'b0, 1'b0), 1'b1, '{8'h03, 1'b0}});
        dir_rows.push_back('{make_pixel(24'h808080, 1'b0, 1'b0), 1'b0, '0});
        dir_rows.push_back('{make_pixel(24'h000000, 1'b0, 1'b0), 1'b0, '0});
        // Rewriting white leaves the cached answer stale until the next image.
        dir_rows.push_back('{make_pal_write(8'd1, 24'h000000), 1'b0, '0});
        dir_rows.push_back('{make_pixel(24'hffffff, 1'b0, 1'b1), 1'b0, '0});
        // After a cache clear: ties between equal distances keep the first entry.
        dir_rows.push_back('{make_pixel(24'hffffff, 1'b1, 1'b0), 1'b0, '0});
        dir_rows.push_back('{make_pixel(24'h000000, 1'b0, 1'b0), 1'b0, '0});
        dir_rows.push_back('{make_pal_write(8'd1, 24'hffffff), 1'b0, '0});
        // Two colors sharing cache slot zero evict each other.
        dir_rows.push_back('{make_pixel(24'h010100, 1'b0, 1'b0), 1'b0, '0});
        dir_rows.push_back('{make_pixel(24'h000000, 1'b0, 1'b0), 1'b0, '0});
        dir_rows.push_back('{make_pixel(24'h010100, 1'b0, 1'b1), 1'b0, '0});
        dir_rows.push_back('{make_pixel(24'hfefefe, 1'b0, 1'b1), 1'b0, '0});
        foreach (dir_rows[i])
            push_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);

        // Fill the whole palette so that every count setting reads written entries.
        for (int s = 0; s < npip_pkg::PALETTE_ENTRIES; s++)
            push_word(make_pal_write(s[7:0], 24'($urandom)), 1'b0, '0);

        // Random phases over a range of depth and count settings.
        for (int p = 0; p < N_PHASES; p++)
        begin
            write_reg(npip_pkg::CFG_DEPTH_MODE, {6'd0, ph_depth[p]});
            write_reg(npip_pkg::CFG_PALETTE_COUNT, ph_count[p]);
            if (p < N_PHASES / 3)
            begin
                sender_idle_pct = 25;
                receiver_idle_pct = 52;
            end
            else if (p < 2 * N_PHASES / 3)
            begin
                sender_idle_pct = 52;
                receiver_idle_pct = 25;
            end
            else
            begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            run_random(PHASE_ITEMS);
        end
        in_valid <= 1'b0;

        while (byte_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("covered %0d pixels and %0d palette writes over %0d depth/count settings",
                 pixels_sent, pal_writes_sent, N_PHASES);
        $display("checked %0d packed bytes, %0d mismatches", bytes_seen, mismatches);
        if (mismatches == 0)
            $display("nearest_palette_index_packer regression: pass");
        else
            $display("nearest_palette_index_packer regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
